[design/ps2dle_pkg.sv]
// ----------------------------------------------------------------------------
// ps2dle_pkg
// Shared types and constants of the PS/2 device link engine.
// ----------------------------------------------------------------------------
package ps2dle_pkg;

   // Transaction kinds on the request channel.
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_ENQUEUE = 1'b1;

   // Bit step codes of the link sequencer.
   localparam logic [3:0] STEP_IDLE      = 4'd0;
   localparam logic [3:0] STEP_START     = 4'd1;
   localparam logic [3:0] STEP_LAST_DATA = 4'd9;
   localparam logic [3:0] STEP_PARITY    = 4'd10;
   localparam logic [3:0] STEP_ACK       = 4'd11;
   localparam logic [3:0] STEP_DONE      = 4'd12;

   // Host commands with a multi-byte reply, and the reply bytes.
   localparam logic [7:0] HOST_RESET   = 8'hFF;
   localparam logic [7:0] HOST_READ_ID = 8'hF2;
   localparam logic [7:0] BYTE_ACK     = 8'hFA;
   localparam logic [7:0] BYTE_BAT_OK  = 8'hAA;
   localparam logic [7:0] BYTE_ID_LOW  = 8'hAB;
   localparam logic [7:0] BYTE_ID_HIGH = 8'h83;
   localparam logic [7:0] RX_MSB       = 8'h80;

   // Reply kinds loaded into the cleared queue.
   localparam logic [1:0] REPLY_ACK   = 2'd0;
   localparam logic [1:0] REPLY_RESET = 2'd1;
   localparam logic [1:0] REPLY_ID    = 2'd2;

   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       pop;
      logic       reply;
      logic [1:0] reply_kind;
   } queue_op_type;

   typedef struct packed {
      logic       not_empty;
      logic [7:0] head_byte;
   } queue_status_type;

   typedef struct packed {
      logic       drive_clock_low;
      logic       drive_data_low;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_done;
   } link_result_type;

endpackage

[design/ps2_device_link_engine_top.sv]
// ----------------------------------------------------------------------------
// ps2_device_link_engine_top
// An accepted transaction is held in the request register until the sequencer
// processes it, and its result is registered in the response register.
// Throughput: one transaction per cycle unless rsp_ready stalls the response,
// set by the single stage of sequencer and queue logic between the registers.
// Reset (synchronous, active high) empties the queue, releases both lines and
// returns the bit step sequencer to idle in device send mode.
// ----------------------------------------------------------------------------
module ps2_device_link_engine_top #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic       req_line_clock,
   input  logic       req_line_data,
   input  logic [7:0] req_send_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_clock_low,
   output logic       rsp_drive_data_low,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_tx_done
);

   // Request register. It holds one accepted transaction until the sequencer
   // processes it; processing happens whenever the response register is free
   // or is being emptied in the same cycle.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_command_ff;
   logic       s1_line_clock_ff;
   logic       s1_line_data_ff;
   logic [7:0] s1_send_byte_ff;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   ps2dle_pkg::link_result_type rsp_ff;

   logic                         advance;
   logic                         fire;
   logic                         req_take;
   ps2dle_pkg::queue_op_type     queue_op;
   ps2dle_pkg::queue_status_type queue_status;
   ps2dle_pkg::link_result_type  link_result;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign fire      = s1_valid_ff & advance;
   assign req_ready = ~s1_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff    <= req_command;
         s1_line_clock_ff <= req_line_clock;
         s1_line_data_ff  <= req_line_data;
         s1_send_byte_ff  <= req_send_byte;
      end
      if (fire) begin
         rsp_ff <= link_result;
      end
   end

   // The sequencer moves through its bit steps on tick transactions and issues
   // at most one queue operation: an enqueue, a removal after a finished send,
   // or a clear-and-load of the reply to a host byte with good parity.
   ps2dle_link u_link (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .command    (s1_command_ff),
      .line_clock (s1_line_clock_ff),
      .line_data  (s1_line_data_ff),
      .send_byte  (s1_send_byte_ff),
      .status     (queue_status),
      .op         (queue_op),
      .result     (link_result)
   );

   // The queue keeps the head byte registered so that a send can start in
   // the same cycle that the start step is processed.
   ps2dle_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .op     (queue_op),
      .status (queue_status)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_clock_low = rsp_ff.drive_clock_low;
   assign rsp_drive_data_low  = rsp_ff.drive_data_low;
   assign rsp_rx_valid        = rsp_ff.rx_valid;
   assign rsp_rx_byte         = rsp_ff.rx_byte;
   assign rsp_tx_done         = rsp_ff.tx_done;

endmodule

[design/ps2dle_queue.sv]
// ----------------------------------------------------------------------------
// ps2dle_queue
// Transmit ring buffer with a registered head read and reply override slots.
// ----------------------------------------------------------------------------
module ps2dle_queue #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ps2dle_pkg::queue_op_type    op,
   output ps2dle_pkg::queue_status_type status
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [7:0]    mem [QUEUE_DEPTH];
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [2:0]    ovr_valid_ff, ovr_valid_in;
   logic [1:0]    ovr_kind_ff, ovr_kind_in;
   logic [7:0]    head_mem_ff;
   logic          ovr_hit;
   logic [7:0]    ovr_byte;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] reply_count(input logic [1:0] kind);
      logic [AW-1:0] n;
      case (kind)
         ps2dle_pkg::REPLY_RESET: n = AW'(2);
         ps2dle_pkg::REPLY_ID:    n = AW'(3);
         default:                 n = AW'(1);
      endcase
      return n;
   endfunction

   function automatic logic [2:0] reply_mask(input logic [1:0] kind);
      logic [2:0] m;
      case (kind)
         ps2dle_pkg::REPLY_RESET: m = 3'b011;
         ps2dle_pkg::REPLY_ID:    m = 3'b111;
         default:                 m = 3'b001;
      endcase
      return m;
   endfunction

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      ovr_valid_in = ovr_valid_ff;
      ovr_kind_in  = ovr_kind_ff;
      if (op.reply) begin
         head_in      = '0;
         tail_in      = reply_count(op.reply_kind);
         ovr_valid_in = reply_mask(op.reply_kind);
         ovr_kind_in  = op.reply_kind;
      end else if (op.push) begin
         tail_in = ring_next(tail_ff);
         if (ring_next(tail_ff) == head_ff) begin
            head_in = ring_next(head_ff);
         end
         // A byte written over a reply slot replaces the reply byte there.
         if (tail_ff < AW'(3)) begin
            ovr_valid_in[tail_ff[1:0]] = 1'b0;
         end
      end else if (op.pop && (head_ff != tail_ff)) begin
         head_in = ring_next(head_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         ovr_valid_ff <= '0;
         ovr_kind_ff  <= ps2dle_pkg::REPLY_ACK;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ovr_valid_ff <= ovr_valid_in;
         ovr_kind_ff  <= ovr_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[tail_ff] <= op.push_byte;
      end
   end

   // The head entry is read into a register from the next head index; a write to that entry bypasses.
   always_ff @(posedge clock) begin
      if (op.push && !op.reply && (tail_ff == head_in)) begin
         head_mem_ff <= op.push_byte;
      end else begin
         head_mem_ff <= mem[head_in];
      end
   end

   always_comb begin
      ovr_hit  = 1'b0;
      ovr_byte = ps2dle_pkg::BYTE_ACK;
      if (head_ff < AW'(3)) begin
         case (head_ff[1:0])
            2'd0: begin
               ovr_hit  = ovr_valid_ff[0];
               ovr_byte = ps2dle_pkg::BYTE_ACK;
            end
            2'd1: begin
               ovr_hit  = ovr_valid_ff[1];
               ovr_byte = (ovr_kind_ff == ps2dle_pkg::REPLY_RESET) ?
                          ps2dle_pkg::BYTE_BAT_OK : ps2dle_pkg::BYTE_ID_LOW;
            end
            default: begin
               ovr_hit  = ovr_valid_ff[2];
               ovr_byte = ps2dle_pkg::BYTE_ID_HIGH;
            end
         endcase
      end
   end

   assign status.not_empty = (head_ff != tail_ff);
   assign status.head_byte = ovr_hit ? ovr_byte : head_mem_ff;

endmodule

[design/ps2dle_link.sv]
// ----------------------------------------------------------------------------
// ps2dle_link
// Bit step sequencer of the PS/2 device link: send, receive and acknowledge.
// ----------------------------------------------------------------------------
module ps2dle_link (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          command,
   input  logic                          line_clock,
   input  logic                          line_data,
   input  logic [7:0]                    send_byte,
   input  ps2dle_pkg::queue_status_type  status,
   output ps2dle_pkg::queue_op_type      op,
   output ps2dle_pkg::link_result_type   result
);

   logic       own_clock_high_ff, own_clock_high_in;
   logic [3:0] bit_step_ff, bit_step_in;
   logic       ones_parity_ff, ones_parity_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic       device_sending_ff, device_sending_in;
   logic       data_held_low_ff, data_held_low_in;
   logic       rx_valid;
   logic       tx_done;

   always_comb begin
      logic [7:0] rx_shift;
      rx_shift          = shift_byte_ff;
      own_clock_high_in = own_clock_high_ff;
      bit_step_in       = bit_step_ff;
      ones_parity_in    = ones_parity_ff;
      shift_byte_in     = shift_byte_ff;
      device_sending_in = device_sending_ff;
      data_held_low_in  = data_held_low_ff;
      op                = '0;
      rx_valid          = 1'b0;
      tx_done           = 1'b0;

      if (fire) begin
         if (command == ps2dle_pkg::CMD_ENQUEUE) begin
            op.push      = 1'b1;
            op.push_byte = send_byte;
         end else if (bit_step_ff == ps2dle_pkg::STEP_IDLE) begin
            // The data line at rest tells whether the host wants to send.
            device_sending_in = line_data;
            if (line_clock) begin
               bit_step_in = ps2dle_pkg::STEP_START;
            end
         end else if (bit_step_ff <= ps2dle_pkg::STEP_PARITY) begin
            if (own_clock_high_ff && line_clock) begin
               if (bit_step_ff == ps2dle_pkg::STEP_START) begin
                  if (device_sending_ff) begin
                     if (status.not_empty) begin
                        shift_byte_in     = status.head_byte;
                        ones_parity_in    = 1'b0;
                        data_held_low_in  = 1'b1;
                        own_clock_high_in = 1'b0;
                     end else begin
                        bit_step_in = ps2dle_pkg::STEP_IDLE;
                     end
                  end else begin
                     shift_byte_in     = '0;
                     ones_parity_in    = 1'b0;
                     own_clock_high_in = 1'b0;
                  end
               end else if (bit_step_ff <= ps2dle_pkg::STEP_LAST_DATA) begin
                  if (device_sending_ff) begin
                     data_held_low_in = ~shift_byte_ff[0];
                     ones_parity_in   = ones_parity_ff ^ shift_byte_ff[0];
                     shift_byte_in    = shift_byte_ff >> 1;
                  end else begin
                     if (line_data) begin
                        rx_shift       = rx_shift | ps2dle_pkg::RX_MSB;
                        ones_parity_in = ~ones_parity_ff;
                     end
                     if (bit_step_ff < ps2dle_pkg::STEP_LAST_DATA) begin
                        rx_shift = rx_shift >> 1;
                     end
                     shift_byte_in = rx_shift;
                  end
                  own_clock_high_in = 1'b0;
               end else begin
                  if (device_sending_ff) begin
                     data_held_low_in = ones_parity_ff;
                  end else if (ones_parity_ff ^ line_data) begin
                     rx_valid = 1'b1;
                     op.reply = 1'b1;
                     if (shift_byte_ff == ps2dle_pkg::HOST_RESET) begin
                        op.reply_kind = ps2dle_pkg::REPLY_RESET;
                     end else if (shift_byte_ff == ps2dle_pkg::HOST_READ_ID) begin
                        op.reply_kind = ps2dle_pkg::REPLY_ID;
                     end else begin
                        op.reply_kind = ps2dle_pkg::REPLY_ACK;
                     end
                  end
                  own_clock_high_in = 1'b0;
               end
            end else if (own_clock_high_ff) begin
               // The host holds the clock low: abort, the byte stays queued.
               data_held_low_in = 1'b0;
               bit_step_in      = ps2dle_pkg::STEP_IDLE;
            end else begin
               own_clock_high_in = 1'b1;
               bit_step_in       = bit_step_ff + 4'd1;
            end
         end else if (bit_step_ff == ps2dle_pkg::STEP_ACK) begin
            if (own_clock_high_ff) begin
               data_held_low_in  = ~device_sending_ff;
               own_clock_high_in = 1'b0;
            end else begin
               own_clock_high_in = 1'b1;
               data_held_low_in  = 1'b0;
               if (device_sending_ff && status.not_empty) begin
                  op.pop  = 1'b1;
                  tx_done = 1'b1;
               end
               bit_step_in = ps2dle_pkg::STEP_DONE;
            end
         end else begin
            bit_step_in = ps2dle_pkg::STEP_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_clock_high_ff <= 1'b1;
         bit_step_ff       <= ps2dle_pkg::STEP_IDLE;
         ones_parity_ff    <= 1'b0;
         shift_byte_ff     <= '0;
         device_sending_ff <= 1'b1;
         data_held_low_ff  <= 1'b0;
      end else begin
         own_clock_high_ff <= own_clock_high_in;
         bit_step_ff       <= bit_step_in;
         ones_parity_ff    <= ones_parity_in;
         shift_byte_ff     <= shift_byte_in;
         device_sending_ff <= device_sending_in;
         data_held_low_ff  <= data_held_low_in;
      end
   end

   assign result.drive_clock_low = ~own_clock_high_in;
   assign result.drive_data_low  = data_held_low_in;
   assign result.rx_valid        = rx_valid;
   assign result.rx_byte         = rx_valid ? shift_byte_ff : 8'h00;
   assign result.tx_done         = tx_done;

endmodule
